// ===== rtl/trcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trcw_pkg
// Shared constants and types of the two-rate cosine waveform generator.
// ----------------------------------------------------------------------------
package trcw_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_RATE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_RATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_PHASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = 3'd4;

	// pi in Q.32 radians and derived limits
	localparam logic [33:0] PI_Q32      = 34'd13493037705;
	localparam logic [33:0] HALF_PI_Q32 = PI_Q32 >> 1;
	localparam logic [34:0] TWO_PI_Q32  = {PI_Q32, 1'b0};

	// half-period for the reset rate of 1.0
	localparam logic [33:0] HALF_RESET     = PI_Q32 / 34'd65536;
	localparam logic [5:0]  HALF_DIV_STEPS = 6'd34;

	localparam int MOD_STAGES = 33;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	localparam int HORNER_STEPS = 5;
	localparam logic [6:0] HORNER_K [HORNER_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
	localparam logic [31:0] HORNER_M [HORNER_STEPS] = '{
		32'((64'd1 << 32) / 64'd90),
		32'((64'd1 << 32) / 64'd56),
		32'((64'd1 << 32) / 64'd30),
		32'((64'd1 << 32) / 64'd12),
		32'((64'd1 << 32) / 64'd2)
	};

	typedef struct packed {
		logic        busy;
		logic [33:0] first_half;
		logic [33:0] second_half;
		logic [34:0] period;
	} half_t;

endpackage

// ===== rtl/trcw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trcw_if
// Valid/ready channels for time samples and drive values.
// ----------------------------------------------------------------------------
interface trcw_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_now;

	modport source (output valid, output time_now, input ready);
	modport sink (input valid, input time_now, output ready);
endinterface

interface trcw_drive_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive_value;

	modport source (output valid, output drive_value, input ready);
	modport sink (input valid, input drive_value, output ready);
endinterface

// ===== rtl/trcw_hdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trcw_hdiv
// Serial restoring dividers for the two half-periods pi/rate and their sum.
// ----------------------------------------------------------------------------
module trcw_hdiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [23:0]         first_rate,
	input  logic [23:0]         second_rate,
	output trcw_pkg::half_t     half
);

	logic [5:0]  cnt_q;
	logic        update_q;
	logic [23:0] rem_q  [2];
	logic [33:0] quo_q  [2];
	logic [33:0] half_q [2];
	logic [34:0] period_q;

	logic [23:0] rate  [2];
	logic [5:0]  bit_idx;
	logic [24:0] trial [2];
	logic [24:0] diff  [2];
	logic [23:0] rem_d [2];
	logic [33:0] quo_d [2];

	assign rate[0] = first_rate;
	assign rate[1] = second_rate;
	assign bit_idx = cnt_q - 6'd1;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial[i] = {rem_q[i], trcw_pkg::PI_Q32[bit_idx]};
			diff[i]  = trial[i] - {1'b0, rate[i]};
			if (trial[i] >= {1'b0, rate[i]}) begin
				rem_d[i] = diff[i][23:0];
				quo_d[i] = {quo_q[i][32:0], 1'b1};
			end else begin
				rem_d[i] = trial[i][23:0];
				quo_d[i] = {quo_q[i][32:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			update_q  <= 1'b0;
			half_q[0] <= trcw_pkg::HALF_RESET;
			half_q[1] <= trcw_pkg::HALF_RESET;
			period_q  <= {1'b0, trcw_pkg::HALF_RESET} + {1'b0, trcw_pkg::HALF_RESET};
		end else begin
			update_q <= 1'b0;
			if (start) begin
				cnt_q <= trcw_pkg::HALF_DIV_STEPS;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					half_q[0] <= quo_d[0];
					half_q[1] <= quo_d[1];
					update_q  <= 1'b1;
				end
			end
			period_q <= {1'b0, half_q[0]} + {1'b0, half_q[1]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (start) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end else if (cnt_q != 6'd0) begin
				rem_q[i] <= rem_d[i];
				quo_q[i] <= quo_d[i];
			end
		end
	end

	assign half.busy        = (cnt_q != 6'd0) || update_q;
	assign half.first_half  = half_q[0];
	assign half.second_half = half_q[1];
	assign half.period      = period_q;

endmodule

// ===== rtl/trcw_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trcw_mod
// Pipelined remainder of the phased time by the period, one bit per stage.
// ----------------------------------------------------------------------------
module trcw_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [32:0] in_sum,
	input  logic [34:0] period,
	output logic        out_valid,
	output logic [34:0] psi
);

	localparam int LAST = trcw_pkg::MOD_STAGES - 1;

	logic        valid_s [trcw_pkg::MOD_STAGES];
	logic [34:0] rem_s   [trcw_pkg::MOD_STAGES];
	logic [31:0] rest_s  [trcw_pkg::MOD_STAGES];

	logic [34:0] rem_in  [trcw_pkg::MOD_STAGES];
	logic        bit_in  [trcw_pkg::MOD_STAGES];
	logic [31:0] rest_d  [trcw_pkg::MOD_STAGES];
	logic [35:0] trial   [trcw_pkg::MOD_STAGES];
	logic [35:0] diff    [trcw_pkg::MOD_STAGES];
	logic [34:0] rem_d   [trcw_pkg::MOD_STAGES];

	always_comb begin
		for (int k = 0; k < trcw_pkg::MOD_STAGES; k++) begin
			if (k == 0) begin
				rem_in[k] = '0;
				bit_in[k] = in_sum[32];
				rest_d[k] = in_sum[31:0];
			end else begin
				rem_in[k] = rem_s[k-1];
				bit_in[k] = rest_s[k-1][31];
				rest_d[k] = {rest_s[k-1][30:0], 1'b0};
			end
			trial[k] = {rem_in[k], bit_in[k]};
			diff[k]  = trial[k] - {1'b0, period};
			if (trial[k] >= {1'b0, period}) begin
				rem_d[k] = diff[k][34:0];
			end else begin
				rem_d[k] = trial[k][34:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < trcw_pkg::MOD_STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			for (int k = 0; k < trcw_pkg::MOD_STAGES; k++) begin
				if (k == 0) begin
					valid_s[k] <= in_valid;
				end else begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < trcw_pkg::MOD_STAGES; k++) begin
				rem_s[k]  <= rem_d[k];
				rest_s[k] <= rest_d[k];
			end
		end
	end

	assign out_valid = valid_s[LAST];
	assign psi       = rem_s[LAST];

endmodule

// ===== rtl/trcw_cos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trcw_cos
// Angle from psi and rate, quadrant fold, and pipelined Horner cosine.
// ----------------------------------------------------------------------------
module trcw_cos (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [34:0]     psi,
	input  trcw_pkg::half_t half,
	input  logic [23:0]     first_rate,
	input  logic [23:0]     second_rate,
	output logic            out_valid,
	output logic [30:0]     cos_mag,
	output logic            cos_neg
);

	localparam int NS = trcw_pkg::HORNER_STEPS;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [34:0] x_s1;
	logic [23:0] rate_s1;
	logic [41:0] lo_s2;
	logic [40:0] hi_s2;
	logic [35:0] theta_s3;
	logic [30:0] x_s4;
	logic        neg_s4, neg_s5;
	logic [61:0] sq_s5;

	logic        va_s   [NS];
	logic        vb_s   [NS];
	logic        vc_s   [NS];
	logic [31:0] x2a_s  [NS];
	logic [31:0] x2b_s  [NS];
	logic [31:0] x2c_s  [NS];
	logic        nega_s [NS];
	logic        negb_s [NS];
	logic        negc_s [NS];
	logic [31:0] na_s   [NS];
	logic [31:0] nb_s   [NS];
	logic [31:0] q0_s   [NS];
	logic [30:0] t_s    [NS];

	logic        first_sel;
	logic [34:0] x_second;
	logic [35:0] r1;
	logic [34:0] r_fold;
	logic [34:0] r_quad;
	logic        quad_neg;

	logic [31:0] x2_in   [NS];
	logic [30:0] t_in    [NS];
	logic        v_in    [NS];
	logic        neg_in  [NS];
	logic [62:0] prod_a  [NS];
	logic [63:0] prod_b  [NS];
	logic [38:0] qk      [NS];
	logic [39:0] rem_c   [NS];
	logic [32:0] q_c     [NS];
	logic [30:0] t_d     [NS];

	always_comb begin
		first_sel = psi < {1'b0, half.first_half};
		x_second  = psi - {1'b0, half.first_half} + {1'b0, half.second_half};
	end

	always_comb begin
		if (theta_s3 > {2'b00, trcw_pkg::PI_Q32}) begin
			r1 = {1'b0, trcw_pkg::TWO_PI_Q32} - theta_s3;
		end else begin
			r1 = theta_s3;
		end
		r_fold = r1[34:0];
		if (r_fold > {1'b0, trcw_pkg::HALF_PI_Q32}) begin
			r_quad   = {1'b0, trcw_pkg::PI_Q32} - r_fold;
			quad_neg = 1'b1;
		end else begin
			r_quad   = r_fold;
			quad_neg = 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			if (i == 0) begin
				x2_in[i]  = sq_s5[61:30];
				t_in[i]   = trcw_pkg::Q30_ONE;
				v_in[i]   = v_s5;
				neg_in[i] = neg_s5;
			end else begin
				x2_in[i]  = x2c_s[i-1];
				t_in[i]   = t_s[i-1];
				v_in[i]   = vc_s[i-1];
				neg_in[i] = negc_s[i-1];
			end
			prod_a[i] = {31'd0, x2_in[i]} * {32'd0, t_in[i]};
			prod_b[i] = {32'd0, na_s[i]} * {32'd0, trcw_pkg::HORNER_M[i]};
			qk[i]     = {7'd0, q0_s[i]} * {32'd0, trcw_pkg::HORNER_K[i]};
			rem_c[i]  = {8'd0, nb_s[i]} - {1'b0, qk[i]};
			if (rem_c[i] >= {33'd0, trcw_pkg::HORNER_K[i]}) begin
				q_c[i] = {1'b0, q0_s[i]} + 33'd1;
			end else begin
				q_c[i] = {1'b0, q0_s[i]};
			end
			if (q_c[i] >= {2'b00, trcw_pkg::Q30_ONE}) begin
				t_d[i] = '0;
			end else begin
				t_d[i] = trcw_pkg::Q30_ONE - q_c[i][30:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < NS; i++) begin
				va_s[i] <= 1'b0;
				vb_s[i] <= 1'b0;
				vc_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			for (int i = 0; i < NS; i++) begin
				va_s[i] <= v_in[i];
				vb_s[i] <= va_s[i];
				vc_s[i] <= vb_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= first_sel ? psi : x_second;
			rate_s1  <= first_sel ? first_rate : second_rate;
			lo_s2    <= {18'd0, rate_s1} * {24'd0, x_s1[17:0]};
			hi_s2    <= {17'd0, rate_s1} * {24'd0, x_s1[34:18]};
			theta_s3 <= lo_s2[35:0] + {hi_s2[17:0], 18'd0};
			x_s4     <= r_quad[32:2];
			neg_s4   <= quad_neg;
			sq_s5    <= {31'd0, x_s4} * {31'd0, x_s4};
			neg_s5   <= neg_s4;
			for (int i = 0; i < NS; i++) begin
				na_s[i]   <= prod_a[i][61:30];
				x2a_s[i]  <= x2_in[i];
				nega_s[i] <= neg_in[i];
				q0_s[i]   <= prod_b[i][63:32];
				nb_s[i]   <= na_s[i];
				x2b_s[i]  <= x2a_s[i];
				negb_s[i] <= nega_s[i];
				t_s[i]    <= t_d[i];
				x2c_s[i]  <= x2b_s[i];
				negc_s[i] <= negb_s[i];
			end
		end
	end

	assign out_valid = vc_s[NS-1];
	assign cos_mag   = t_s[NS-1];
	assign cos_neg   = negc_s[NS-1];

endmodule

// ===== rtl/two_rate_cosine_waveform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_rate_cosine_waveform
// Asymmetric cosine drive generator: time sample in, drive value out.
// ----------------------------------------------------------------------------
// usage
//   sample: valid/ready channel carrying time_now (Q16.16 s)
//   drive:  valid/ready channel carrying drive_value (signed Q16.16, saturated)
//   cfg_we/cfg_index/cfg_data write amplitude, rates, time phase and offset
// throughput: one sample per cycle, set by the fully pipelined datapath,
//   while the queue has room and the dividers are idle; its path includes
//   33 remainder stages, one bit each, and 15 stages for the cosine series
// a rate write starts the half-period dividers: sample.ready is low
//   while pi/rate is worked out one quotient bit per cycle
// reset clears the pipeline and output queue and loads default registers
//   (unit amplitude, unit rates, zero phase and offset); no sweep is needed
// a stalled receiver fills a two-entry output queue; the pipeline keeps
//   moving and taking samples until the queue is full, then holds in place
// ----------------------------------------------------------------------------
module two_rate_cosine_waveform (
	input  logic                               clk,
	input  logic                               arst_n,
	trcw_sample_if.sink                        sample,
	trcw_drive_if.source                       drive,
	input  logic                               cfg_we,
	input  logic [trcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [trcw_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [23:0] amp_q;
	logic [23:0] w1_q;
	logic [23:0] w2_q;
	logic [31:0] phase_q;
	logic [23:0] ofs_q;

	logic [23:0] w1;
	logic [23:0] w2;
	logic        rate_write;
	trcw_pkg::half_t half;

	logic        en;
	logic        v_s1;
	logic [32:0] sum_s1;
	logic        mod_valid;
	logic [34:0] psi;
	logic        cos_valid;
	logic [30:0] cos_mag;
	logic        cos_neg;
	logic        v_s2;
	logic [54:0] prod_s2;
	logic        neg_s2;

	logic [23:0] amp_mag;
	logic [55:0] rnd;
	logic [25:0] mag_r;
	logic signed [33:0] sval;
	logic signed [33:0] total;
	logic [31:0] result;

	logic [31:0] buf_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  q_cnt_q;
	logic        push;
	logic        pop;

	assign w1 = (w1_q == 24'd0) ? 24'd1 : w1_q;
	assign w2 = (w2_q == 24'd0) ? 24'd1 : w2_q;
	assign rate_write = cfg_we && (cfg_index == trcw_pkg::REG_FIRST_RATE ||
		cfg_index == trcw_pkg::REG_SECOND_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q   <= 24'd65536;
			w1_q    <= 24'd65536;
			w2_q    <= 24'd65536;
			phase_q <= '0;
			ofs_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				trcw_pkg::REG_AMPLITUDE: begin
					amp_q <= cfg_data[23:0];
				end
				trcw_pkg::REG_FIRST_RATE: begin
					w1_q <= cfg_data[23:0];
				end
				trcw_pkg::REG_SECOND_RATE: begin
					w2_q <= cfg_data[23:0];
				end
				trcw_pkg::REG_TIME_PHASE: begin
					phase_q <= cfg_data[31:0];
				end
				trcw_pkg::REG_LEVEL_OFFSET: begin
					ofs_q <= cfg_data[23:0];
				end
				default: begin
				end
			endcase
		end
	end

	trcw_hdiv u_hdiv (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (rate_write),
		.first_rate  (w1),
		.second_rate (w2),
		.half        (half)
	);

	assign en           = (q_cnt_q != 2'd2);
	assign sample.ready = en && !half.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid && sample.ready;
			v_s2 <= cos_valid;
		end
	end

	assign amp_mag = amp_q[23] ? (24'd0 - amp_q) : amp_q;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= {1'b0, sample.time_now} + {1'b0, phase_q};
			prod_s2 <= {31'd0, amp_mag} * {24'd0, cos_mag};
			neg_s2  <= cos_neg ^ amp_q[23];
		end
	end

	trcw_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_sum    (sum_s1),
		.period    (half.period),
		.out_valid (mod_valid),
		.psi       (psi)
	);

	trcw_cos u_cos (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (mod_valid),
		.psi         (psi),
		.half        (half),
		.first_rate  (w1),
		.second_rate (w2),
		.out_valid   (cos_valid),
		.cos_mag     (cos_mag),
		.cos_neg     (cos_neg)
	);

	// round, sign, offset and saturate
	always_comb begin
		rnd   = {1'b0, prod_s2} + 56'h2000_0000;
		mag_r = rnd[55:30];
		sval  = neg_s2 ? -$signed({8'd0, mag_r}) : $signed({8'd0, mag_r});
		total = sval + $signed({{10{ofs_q[23]}}, ofs_q});
		if (total > 34'sh0_7FFF_FFFF) begin
			result = 32'h7FFF_FFFF;
		end else if (total < -34'sh0_8000_0000) begin
			result = 32'h8000_0000;
		end else begin
			result = total[31:0];
		end
	end

	// output queue
	assign push = en && v_s2;
	assign pop  = drive.valid && drive.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			q_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= result;
		end
	end

	assign drive.valid       = (q_cnt_q != 2'd0);
	assign drive.drive_value = buf_q[rd_q];

`ifndef SYNTHESIS
	a_rate_write_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rate_write |=> !sample.ready)
		else $error("sample taken while half-periods are recomputed");

	a_no_transfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |-> !half.busy)
		else $error("sample transfer during divider run");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_cnt_q == 2'd2) && !pop |=> (q_cnt_q == 2'd2))
		else $error("output queue lost an entry");
`endif

endmodule

// ===== sim/two_rate_cosine_waveform_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_rate_cosine_waveform_checker
// Watches the sample, drive and register ports, predicts each drive value
// from its own copy of the registers and compares it with the block output.
// ----------------------------------------------------------------------------
module two_rate_cosine_waveform_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	trcw_sample_if                          sample,
	trcw_drive_if                           drive,
	input  logic                            cfg_we,
	input  logic [trcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trcw_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);

	logic [23:0] amp_r;
	logic [23:0] rate1_r;
	logic [23:0] rate2_r;
	logic [31:0] phase_r;
	logic [23:0] offs_r;

	logic signed [31:0] drive_expected [$];

	assign pending = drive_expected.size();

	function automatic logic signed [31:0] drive_predict(logic [31:0] tn);
		longint unsigned pi, w1, w2, h1, h2, s, psi, th, r, x, x2, t, q, mag, m;
		longint unsigned kdiv [5];
		longint a, v;
		bit neg;
		pi = 64'(trcw_pkg::PI_Q32);
		kdiv = '{90, 56, 30, 12, 2};
		w1 = (rate1_r == 0) ? 1 : 64'(rate1_r);
		w2 = (rate2_r == 0) ? 1 : 64'(rate2_r);
		h1 = pi / w1;
		h2 = pi / w2;
		s = 64'(tn) + 64'(phase_r);
		psi = s % (h1 + h2);
		if (psi < h1)
			th = w1 * psi;
		else
			th = w2 * (psi - h1 + h2);
		r = th % (2 * pi);
		neg = 0;
		if (r > pi)
			r = 2 * pi - r;
		if (r > (pi >> 1)) begin
			r = pi - r;
			neg = 1;
		end
		x = r >> 2;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int i = 0; i < 5; i++) begin
			q = ((x2 * t) >> 30) / kdiv[i];
			t = (q >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - q;
		end
		a = longint'(signed'(amp_r));
		if (a < 0) begin
			mag = -a;
			neg = !neg;
		end else begin
			mag = a;
		end
		m = (mag * t + (64'd1 << 29)) >> 30;
		v = neg ? -longint'(m) : longint'(m);
		v += longint'(signed'(offs_r));
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] want;
		if (!arst_n) begin
			amp_r   <= 24'd65536;
			rate1_r <= 24'd65536;
			rate2_r <= 24'd65536;
			phase_r <= '0;
			offs_r  <= '0;
			errors  = 0;
			drive_expected.delete();
		end else begin
			if (sample.valid && sample.ready)
				drive_expected.push_back(drive_predict(sample.time_now));
			if (drive.valid && drive.ready) begin
				if (drive_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected drive_value %0d", drive.drive_value));
				end else begin
					want = drive_expected.pop_front();
					if (drive.drive_value !== want)
						report_mismatch($sformatf("drive_value %0d, predicted %0d",
							drive.drive_value, want));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					trcw_pkg::REG_AMPLITUDE:    amp_r   <= cfg_data[23:0];
					trcw_pkg::REG_FIRST_RATE:   rate1_r <= cfg_data[23:0];
					trcw_pkg::REG_SECOND_RATE:  rate2_r <= cfg_data[23:0];
					trcw_pkg::REG_TIME_PHASE:   phase_r <= cfg_data;
					trcw_pkg::REG_LEVEL_OFFSET: offs_r  <= cfg_data[23:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== sim/two_rate_cosine_waveform_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_rate_cosine_waveform_tb
// Drives time samples and register settings into the waveform generator
// under random idling and back-pressure; the checker predicts every drive
// value and this top gives the verdict.
// ----------------------------------------------------------------------------
module two_rate_cosine_waveform_tb;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [trcw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [trcw_pkg::CFG_DATA_W-1:0] cfg_data;

	int errors;
	int pending;
	int snd_idle;
	int rcv_idle;
	int stall_cnt;
	bit hold_go;

	trcw_sample_if sample ();
	trcw_drive_if  drive ();

	two_rate_cosine_waveform u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.drive     (drive),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	two_rate_cosine_waveform_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.drive     (drive),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// receiver, with a long hold-off on request
	always begin
		@(negedge clk);
		if (hold_go) begin
			drive.ready <= 1'b0;
			repeat (400) @(negedge clk);
			hold_go = 0;
		end
		drive.ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (drive.valid && drive.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= 4000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_sample(logic [31:0] t);
		while ($urandom_range(99) < snd_idle) begin
			sample.valid <= 1'b0;
			@(negedge clk);
		end
		sample.valid    <= 1'b1;
		sample.time_now <= t;
		do @(posedge clk); while (!sample.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		sample.valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (70) @(negedge clk);
	endtask

	task automatic write_reg(logic [trcw_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFFFF;
			2: return 32'(1);
			3: return {8'($urandom), 24'($urandom_range(1, 24'hFFFFFF))};
			default: return 32'($urandom_range(24'h1000, 24'h100000));
		endcase
	endfunction

	function automatic logic [31:0] pick_signed24();
		case ($urandom_range(4))
			0: return 32'h7FFFFF;
			1: return 32'hFF800000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(3))
			0: return 32'($urandom_range(0, 32'h00100000));
			1: return 32'hFFFFFFFF - 32'($urandom_range(0, 4096));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] dir_times [] = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h80000000,
			32'h7FFFFFFF, 32'd102943, 32'd205886, 32'd205887, 32'd205888,
			32'd308830, 32'd411773, 32'd411774, 32'd411775};
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		sample.valid    = 1'b0;
		sample.time_now = '0;
		drive.ready     = 1'b0;
		snd_idle        = 31;
		rcv_idle        = 80;
		hold_go         = 0;
		stall_cnt       = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_times[i])
			send_sample(dir_times[i]);
		settle();

		// extremes, dropped upper bits and ignored indexes
		write_reg(trcw_pkg::REG_AMPLITUDE, 32'hFF7FFFFF);
		write_reg(trcw_pkg::REG_FIRST_RATE, 32'hFFFFFFFF);
		write_reg(trcw_pkg::REG_SECOND_RATE, 32'h1);
		write_reg(trcw_pkg::REG_TIME_PHASE, 32'hFFFFFFFF);
		write_reg(trcw_pkg::REG_LEVEL_OFFSET, 32'h00800000);
		write_reg(trcw_pkg::CFG_IDX_W'(5), $urandom);
		write_reg(trcw_pkg::CFG_IDX_W'(7), $urandom);
		cfg_we <= 1'b0;
		@(negedge clk);
		foreach (dir_times[i])
			if (i < 6)
				send_sample(dir_times[i]);
		settle();

		// zero rates
		write_reg(trcw_pkg::REG_AMPLITUDE, 32'h800000);
		write_reg(trcw_pkg::REG_FIRST_RATE, 32'h0);
		write_reg(trcw_pkg::REG_SECOND_RATE, 32'h0);
		write_reg(trcw_pkg::REG_TIME_PHASE, 32'h0);
		write_reg(trcw_pkg::REG_LEVEL_OFFSET, 32'h7FFFFF);
		cfg_we <= 1'b0;
		@(negedge clk);
		send_sample(32'h0);
		send_sample(32'hFFFFFFFF);
		send_sample(32'h12345678);
		settle();

		for (int p = 0; p < 12; p++) begin
			if (p == 4) begin
				snd_idle = 80;
				rcv_idle = 31;
			end
			if (p == 8) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			write_reg(trcw_pkg::REG_AMPLITUDE, pick_signed24());
			write_reg(trcw_pkg::REG_FIRST_RATE, pick_rate());
			write_reg(trcw_pkg::REG_SECOND_RATE, pick_rate());
			write_reg(trcw_pkg::REG_TIME_PHASE, ($urandom_range(2) == 0) ? 32'h0 : $urandom);
			write_reg(trcw_pkg::REG_LEVEL_OFFSET, pick_signed24());
			cfg_we <= 1'b0;
			@(negedge clk);
			if (p == 9)
				hold_go = 1;
			for (int i = 0; i < 110; i++) begin
				if (p == 10 && i == 50) begin
					sample.valid <= 1'b0;
					@(negedge clk);
					wait (pending == 0);
					@(negedge clk);
				end
				send_sample(pick_time());
			end
			settle();
		end

		repeat (70) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
